[src/plob_pkg.sv]
// Package for the price-level order book.
// Holds the word types of both channels and the level and control structs shared
// by the cell, side and top modules. Depends on nothing.
package plob_pkg;

    localparam int PRICE_W = 32;
    localparam int QIN_W   = 32;
    localparam int QTY_W   = 48;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REDUCE = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic               is_buy_side;
        logic [PRICE_W-1:0] price_ticks;
        logic [QIN_W-1:0]   quantity;
    } in_word_t;

    typedef struct packed {
        logic               bid_present;
        logic [PRICE_W-1:0] top_bid_price;
        logic               ask_present;
        logic [PRICE_W-1:0] top_ask_price;
        logic               overflow;
    } out_word_t;

    typedef struct packed {
        logic               vld;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
    } level_t;

    typedef struct packed {
        logic               en;
        logic               op;
        logic               desc;
        logic [PRICE_W-1:0] price;
        logic [QIN_W-1:0]   qty;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic full;
        logic remove;
    } glb_t;

endpackage

[src/plob_cell.sv]
// One price level of a side: holds a level and updates it from the broadcast command
// and the levels of its two neighbors. Depends on plob_pkg.
module plob_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  plob_pkg::cmd_t   cmd,
    input  plob_pkg::glb_t   glb,
    input  plob_pkg::level_t left_lvl,
    input  logic             left_ahead,
    input  plob_pkg::level_t right_lvl,
    output plob_pkg::level_t lvl,
    output logic             ahead,
    output logic             match,
    output logic             kill
);

    plob_pkg::level_t lvl_reg;
    plob_pkg::level_t lvl_next;
    logic [plob_pkg::QTY_W:0] sum;
    logic [plob_pkg::QTY_W-1:0] qin_ext;
    logic ins_here;

    assign qin_ext  = {{(plob_pkg::QTY_W - plob_pkg::QIN_W){1'b0}}, cmd.qty};
    assign sum      = {1'b0, lvl_reg.qty} + {1'b0, qin_ext};
    assign match    = lvl_reg.vld && (lvl_reg.price == cmd.price);
    assign ahead    = lvl_reg.vld && (cmd.desc ? (lvl_reg.price > cmd.price)
                                               : (lvl_reg.price < cmd.price));
    assign kill     = match && (qin_ext >= lvl_reg.qty);
    assign ins_here = !ahead && left_ahead;
    assign lvl      = lvl_reg;

    always_comb
    begin
        lvl_next = lvl_reg;
        if (cmd.en)
        begin
            if (cmd.op == plob_pkg::OP_ADD)
            begin
                priority if (glb.hit)
                begin
                    if (match)
                    begin
                        lvl_next.qty = sum[plob_pkg::QTY_W] ? {plob_pkg::QTY_W{1'b1}}
                                                            : sum[plob_pkg::QTY_W-1:0];
                    end
                end
                else if (!glb.full)
                begin
                    if (ins_here)
                    begin
                        lvl_next.vld   = 1'b1;
                        lvl_next.price = cmd.price;
                        lvl_next.qty   = qin_ext;
                    end
                    else if (!ahead)
                    begin
                        lvl_next = left_lvl;
                    end
                end
                else
                begin
                    lvl_next = lvl_reg;
                end
            end
            else
            begin
                priority if (glb.remove)
                begin
                    if (!ahead)
                    begin
                        lvl_next = right_lvl;
                    end
                end
                else if (match)
                begin
                    lvl_next.qty = lvl_reg.qty - qin_ext;
                end
                else
                begin
                    lvl_next = lvl_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lvl_reg <= '0;
        end
        else
        begin
            lvl_reg <= lvl_next;
        end
    end

endmodule

[src/plob_side.sv]
// One side of the book: a row of level cells kept sorted best price first.
// Depends on plob_pkg and plob_cell.
module plob_side #(
    parameter int LEVELS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  plob_pkg::cmd_t   cmd,
    output plob_pkg::level_t best,
    output logic             full,
    output logic             overflow
);

    plob_pkg::level_t lvl [LEVELS];
    logic [LEVELS-1:0] ahead;
    logic [LEVELS-1:0] match;
    logic [LEVELS-1:0] kill;
    plob_pkg::glb_t glb;

    assign glb.hit    = |match;
    assign glb.full   = lvl[LEVELS-1].vld;
    assign glb.remove = |kill;
    assign full       = glb.full;
    assign best       = lvl[0];
    assign overflow   = cmd.en && (cmd.op == plob_pkg::OP_ADD) && !glb.hit && glb.full;

    for (genvar i = 0; i < LEVELS; i++)
    begin : g_cell
        plob_pkg::level_t left_lvl;
        plob_pkg::level_t right_lvl;
        logic left_ahead;

        if (i == 0)
        begin : g_first
            assign left_lvl   = '0;
            assign left_ahead = 1'b1;
        end
        else
        begin : g_mid
            assign left_lvl   = lvl[i-1];
            assign left_ahead = ahead[i-1];
        end

        if (i == LEVELS - 1)
        begin : g_last
            assign right_lvl = '0;
        end
        else
        begin : g_inner
            assign right_lvl = lvl[i+1];
        end

        plob_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .glb        (glb),
            .left_lvl   (left_lvl),
            .left_ahead (left_ahead),
            .right_lvl  (right_lvl),
            .lvl        (lvl[i]),
            .ahead      (ahead[i]),
            .match      (match[i]),
            .kill       (kill[i])
        );
    end

endmodule

[src/price_level_order_book_top.sv]
// Top level of the price-level order book: two sides of level cells and the result register.
// Depends on plob_pkg and plob_side.
// Latency: the result word for an accepted word is valid in the next cycle.
// Throughput: one word per cycle unless out_ready stalls; side cells update on acceptance.
// Reset clears all levels on both sides and the result register.
module price_level_order_book_top #(
    parameter int LEVELS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  plob_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output plob_pkg::out_word_t out_data
);

    logic out_valid_reg;
    logic out_valid_next;
    logic ovf_reg;
    logic ovf_next;
    logic accept;
    plob_pkg::cmd_t bid_cmd;
    plob_pkg::cmd_t ask_cmd;
    plob_pkg::level_t bid_best;
    plob_pkg::level_t ask_best;
    logic bid_full;
    logic ask_full;
    logic bid_ovf;
    logic ask_ovf;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign bid_cmd.en    = accept && in_data.is_buy_side;
    assign bid_cmd.op    = in_data.opcode;
    assign bid_cmd.desc  = 1'b1;
    assign bid_cmd.price = in_data.price_ticks;
    assign bid_cmd.qty   = in_data.quantity;

    assign ask_cmd.en    = accept && !in_data.is_buy_side;
    assign ask_cmd.op    = in_data.opcode;
    assign ask_cmd.desc  = 1'b0;
    assign ask_cmd.price = in_data.price_ticks;
    assign ask_cmd.qty   = in_data.quantity;

    plob_side #(.LEVELS(LEVELS)) u_bid (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (bid_cmd),
        .best     (bid_best),
        .full     (bid_full),
        .overflow (bid_ovf)
    );

    plob_side #(.LEVELS(LEVELS)) u_ask (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (ask_cmd),
        .best     (ask_best),
        .full     (ask_full),
        .overflow (ask_ovf)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        ovf_next       = ovf_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            ovf_next       = bid_ovf || ask_ovf;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            ovf_reg       <= ovf_next;
        end
    end

    assign out_valid              = out_valid_reg;
    assign out_data.bid_present   = bid_best.vld;
    assign out_data.top_bid_price = bid_best.vld ? bid_best.price : '0;
    assign out_data.ask_present   = ask_best.vld;
    assign out_data.top_ask_price = ask_best.vld ? ask_best.price : '0;
    assign out_data.overflow      = ovf_reg;

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted word produced no result word");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid_reg && !out_ready))
        else $error("input stalled without a pending result word");

    a_overflow_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (bid_full || ask_full))
        else $error("overflow reported while neither side is full");

endmodule

[sim/tb_price_level_order_book_top.sv]
// Testbench for price_level_order_book_top: drives book update words, predicts the
// best bid and ask of both sides and checks every result word. Depends on plob_pkg
// and the RTL of the order book.
module tb_price_level_order_book_top;

    localparam int BOOK_DEPTH = 16;
    localparam int IDLE_LIMIT = 2000;
    localparam int ASK = 0;
    localparam int BID = 1;
    localparam logic [plob_pkg::QTY_W-1:0]   QTY_SAT = '1;
    localparam logic [plob_pkg::QIN_W-1:0]   QIN_MAX = '1;
    localparam logic [plob_pkg::PRICE_W-1:0] PX_MAX  = '1;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    plob_pkg::in_word_t  in_data = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    plob_pkg::out_word_t out_data;

    logic [plob_pkg::PRICE_W-1:0] lvl_px [2][BOOK_DEPTH];
    logic [plob_pkg::QTY_W-1:0]   lvl_qty[2][BOOK_DEPTH];
    int                           lvl_n[2] = '{0, 0};

    plob_pkg::out_word_t          top_of_book_q[$];
    logic [plob_pkg::PRICE_W-1:0] price_pool[$];
    int                           error_count = 0;
    int                           idle_cycles = 0;
    bit                           src_gaps = 1'b0;
    bit                           sink_gaps = 1'b0;
    int                           sink_hold_len = 0;

    price_level_order_book_top #(
        .LEVELS(BOOK_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic plob_pkg::in_word_t make_word(logic op, logic side,
                                                     logic [plob_pkg::PRICE_W-1:0] px,
                                                     logic [plob_pkg::QIN_W-1:0] q);
        plob_pkg::in_word_t w;
        w.opcode = op;
        w.is_buy_side = side;
        w.price_ticks = px;
        w.quantity = q;
        return w;
    endfunction

    function automatic plob_pkg::out_word_t book_apply(plob_pkg::in_word_t w);
        int                       s;
        int                       f;
        int                       pos;
        int                       j;
        logic [plob_pkg::QTY_W:0] sum;
        plob_pkg::out_word_t      r;
        s = w.is_buy_side ? BID : ASK;
        f = -1;
        r = '0;
        for (int i = 0; i < lvl_n[s]; i++)
        begin
            if (f < 0 && lvl_px[s][i] == w.price_ticks)
                f = i;
        end
        if (w.opcode == plob_pkg::OP_REDUCE)
        begin
            if (f >= 0)
            begin
                if (plob_pkg::QTY_W'(w.quantity) < lvl_qty[s][f])
                    lvl_qty[s][f] = lvl_qty[s][f] - plob_pkg::QTY_W'(w.quantity);
                else
                begin
                    for (j = f; j + 1 < lvl_n[s]; j++)
                    begin
                        lvl_px[s][j] = lvl_px[s][j + 1];
                        lvl_qty[s][j] = lvl_qty[s][j + 1];
                    end
                    lvl_n[s]--;
                end
            end
        end
        else if (f >= 0)
        begin
            sum = {1'b0, lvl_qty[s][f]} + (plob_pkg::QTY_W + 1)'(w.quantity);
            lvl_qty[s][f] = (sum > {1'b0, QTY_SAT}) ? QTY_SAT : sum[plob_pkg::QTY_W-1:0];
        end
        else if (lvl_n[s] >= BOOK_DEPTH)
            r.overflow = 1'b1;
        else
        begin
            pos = lvl_n[s];
            for (int i = lvl_n[s] - 1; i >= 0; i--)
            begin
                if (s == BID ? (w.price_ticks > lvl_px[s][i]) : (w.price_ticks < lvl_px[s][i]))
                    pos = i;
            end
            for (j = lvl_n[s]; j > pos; j--)
            begin
                lvl_px[s][j] = lvl_px[s][j - 1];
                lvl_qty[s][j] = lvl_qty[s][j - 1];
            end
            lvl_px[s][pos] = w.price_ticks;
            lvl_qty[s][pos] = plob_pkg::QTY_W'(w.quantity);
            lvl_n[s]++;
        end
        r.bid_present = lvl_n[BID] > 0;
        r.top_bid_price = (lvl_n[BID] > 0) ? lvl_px[BID][0] : '0;
        r.ask_present = lvl_n[ASK] > 0;
        r.top_ask_price = (lvl_n[ASK] > 0) ? lvl_px[ASK][0] : '0;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (error_count < 100)
            $display("%0t: mismatch in %s: got %h, expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin : book_scoreboard
        plob_pkg::out_word_t want;
        if (rst_n && in_valid && in_ready)
            top_of_book_q.push_back(book_apply(in_data));
        if (rst_n && out_valid && out_ready)
        begin
            if (top_of_book_q.size() == 0)
                report_mismatch("result word with nothing expected", out_data.top_bid_price, '0);
            else
            begin
                want = top_of_book_q.pop_front();
                if (out_data.bid_present !== want.bid_present)
                    report_mismatch("bid_present", 32'(out_data.bid_present),
                                    32'(want.bid_present));
                if (out_data.top_bid_price !== want.top_bid_price)
                    report_mismatch("top_bid_price", out_data.top_bid_price, want.top_bid_price);
                if (out_data.ask_present !== want.ask_present)
                    report_mismatch("ask_present", 32'(out_data.ask_present),
                                    32'(want.ask_present));
                if (out_data.top_ask_price !== want.top_ask_price)
                    report_mismatch("top_ask_price", out_data.top_ask_price, want.top_ask_price);
                if (out_data.overflow !== want.overflow)
                    report_mismatch("overflow", 32'(out_data.overflow), 32'(want.overflow));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin : result_sink
        int gap;
        forever
        begin
            gap = sink_gaps ? $urandom_range(0, 15) : 0;
            if (sink_hold_len > 0)
            begin
                gap = sink_hold_len;
                sink_hold_len = 0;
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
        end
    end

    task automatic send_word(plob_pkg::in_word_t w);
        int gap;
        gap = src_gaps ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
    endtask

    task automatic wait_book_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (top_of_book_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic clear_book();
        logic [plob_pkg::PRICE_W-1:0] px_snap[$];
        logic [plob_pkg::QTY_W-1:0]   qty_snap[$];
        logic                         side_snap[$];
        logic [plob_pkg::QTY_W-1:0]   left;
        wait_book_idle();
        for (int s = 0; s < 2; s++)
        begin
            for (int i = 0; i < lvl_n[s]; i++)
            begin
                px_snap.push_back(lvl_px[s][i]);
                qty_snap.push_back(lvl_qty[s][i]);
                side_snap.push_back(s == BID);
            end
        end
        foreach (px_snap[i])
        begin
            left = qty_snap[i];
            send_word(make_word(plob_pkg::OP_REDUCE, side_snap[i], px_snap[i], QIN_MAX));
            while (left > plob_pkg::QTY_W'(QIN_MAX))
            begin
                left = left - plob_pkg::QTY_W'(QIN_MAX);
                send_word(make_word(plob_pkg::OP_REDUCE, side_snap[i], px_snap[i], QIN_MAX));
            end
        end
        wait_book_idle();
    endtask

    task automatic fill_price_pool(int size);
        price_pool.delete();
        price_pool.push_back('0);
        price_pool.push_back(PX_MAX);
        while (price_pool.size() < size)
            price_pool.push_back($urandom());
    endtask

    function automatic plob_pkg::in_word_t random_word(int add_pct);
        plob_pkg::in_word_t w;
        w.opcode = ($urandom_range(0, 99) < add_pct) ? plob_pkg::OP_ADD : plob_pkg::OP_REDUCE;
        w.is_buy_side = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) == 0 || price_pool.size() == 0)
            w.price_ticks = $urandom();
        else
            w.price_ticks = price_pool[$urandom_range(0, price_pool.size() - 1)];
        case ($urandom_range(0, 5))
            0: w.quantity = '0;
            1: w.quantity = QIN_MAX;
            2: w.quantity = $urandom_range(1, 100);
            default: w.quantity = $urandom();
        endcase
        return w;
    endfunction

    task automatic test_book_edges();
        src_gaps = 1'b1;
        sink_gaps = 1'b1;
        send_word(make_word(plob_pkg::OP_ADD, 1'b1, 32'd100, '0));
        send_word(make_word(plob_pkg::OP_REDUCE, 1'b1, 32'd100, '0));
        send_word(make_word(plob_pkg::OP_REDUCE, 1'b0, 32'd500, 32'd5));
        send_word(make_word(plob_pkg::OP_ADD, 1'b0, PX_MAX, QIN_MAX));
        send_word(make_word(plob_pkg::OP_ADD, 1'b0, '0, 32'd1));
        send_word(make_word(plob_pkg::OP_ADD, 1'b1, '0, 32'd7));
        send_word(make_word(plob_pkg::OP_ADD, 1'b1, PX_MAX, 32'd1));
        send_word(make_word(plob_pkg::OP_ADD, 1'b1, PX_MAX, QIN_MAX));
        send_word(make_word(plob_pkg::OP_REDUCE, 1'b1, PX_MAX, QIN_MAX));
        send_word(make_word(plob_pkg::OP_REDUCE, 1'b1, PX_MAX, 32'd2));
        send_word(make_word(plob_pkg::OP_REDUCE, 1'b0, '0, 32'd1));
        send_word(make_word(plob_pkg::OP_REDUCE, 1'b0, PX_MAX, QIN_MAX - 1));
        send_word(make_word(plob_pkg::OP_ADD, 1'b0, 32'h8000_0000, 32'h5555_5555));
        send_word(make_word(plob_pkg::OP_ADD, 1'b1, 32'h7FFF_FFFF, 32'hAAAA_AAAA));
        clear_book();
    endtask

    task automatic test_side_full();
        src_gaps = 1'b0;
        sink_gaps = 1'b0;
        for (int i = 0; i < BOOK_DEPTH; i++)
            send_word(make_word(plob_pkg::OP_ADD, 1'b1, ((i * 37) % BOOK_DEPTH) * 1000 + 5,
                                i + 1));
        send_word(make_word(plob_pkg::OP_ADD, 1'b1, 32'd999_999, 32'd3));
        send_word(make_word(plob_pkg::OP_ADD, 1'b1, 32'd5, 32'd3));
        send_word(make_word(plob_pkg::OP_REDUCE, 1'b1, 32'd1, 32'd3));
        clear_book();
    endtask

    task automatic test_random_flow();
        int pool_sizes[4] = '{6, 20, 40, 24};
        for (int phase = 0; phase < 4; phase++)
        begin
            src_gaps = phase[0];
            sink_gaps = phase[1];
            fill_price_pool(pool_sizes[phase]);
            repeat (380) send_word(random_word(60));
        end
        wait_book_idle();
    endtask

    task automatic test_output_backpressure();
        src_gaps = 1'b0;
        sink_gaps = 1'b0;
        fill_price_pool(12);
        sink_hold_len = 300;
        repeat (40) send_word(random_word(60));
        wait_book_idle();
    endtask

    task automatic test_level_accumulate();
        clear_book();
        src_gaps = 1'b0;
        sink_gaps = 1'b0;
        repeat (8) send_word(make_word(plob_pkg::OP_ADD, 1'b1, 32'h00C0_FFEE, QIN_MAX));
        send_word(make_word(plob_pkg::OP_REDUCE, 1'b1, 32'h00C0_FFEE, QIN_MAX));
        send_word(make_word(plob_pkg::OP_ADD, 1'b0, 32'h00C0_FFEF, 32'd1));
        clear_book();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_book_edges();
        test_side_full();
        test_random_flow();
        test_output_backpressure();
        test_level_accumulate();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
